@@ rtl/core/lps_pkg.sv @@
// Package for the LED pattern sequencer: pattern mode codes and LED constants.
// No dependencies; used by the channel interfaces and the top level.
package lps_pkg;

    typedef enum logic [1:0] {
        MODE_TOGGLE   = 2'd0,
        MODE_WALK     = 2'd1,
        MODE_CONVERGE = 2'd2,
        MODE_FILL     = 2'd3
    } t_mode;

    localparam int LED_W = 8;
    localparam int MODE_BTN_W = 4;
    localparam int SPEED_BTN_W = 2;

    localparam logic [LED_W-1:0] LEDS_ALL_ON      = 8'hFF;
    localparam logic [LED_W-1:0] LEDS_ALL_OFF     = 8'h00;
    localparam logic [LED_W-1:0] LEDS_LOW_BIT     = 8'd1;
    localparam logic [LED_W-1:0] LEDS_HIGH_BIT    = 8'd128;
    localparam logic [LED_W-1:0] LIGHT_WRAP_LEFT  = 8'd2;
    localparam logic [LED_W-1:0] LIGHT_WRAP_RIGHT = 8'd64;
    localparam logic [LED_W-1:0] LIGHT_MID_LEFT   = 8'd8;
    localparam logic [LED_W-1:0] LIGHT_SKIP_LEFT  = 8'd32;
    localparam logic [LED_W-1:0] LIGHT_SKIP_RIGHT = 8'd4;

endpackage

@@ rtl/core/lps_in_if.sv @@
// Input channel of the LED pattern sequencer: one tick with button levels.
// Depends on lps_pkg for the field widths.
interface lps_in_if;
    import lps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   start_n;
    logic                   stop_n;
    logic [MODE_BTN_W-1:0]  mode_buttons_n;
    logic [SPEED_BTN_W-1:0] speed_buttons_n;

    modport source (output valid, start_n, stop_n, mode_buttons_n, speed_buttons_n,
                    input ready);
    modport sink   (input valid, start_n, stop_n, mode_buttons_n, speed_buttons_n,
                    output ready);
endinterface

@@ rtl/core/lps_out_if.sv @@
// Output channel of the LED pattern sequencer: LED levels and the running flag.
// Depends on lps_pkg for the field widths.
interface lps_out_if;
    import lps_pkg::*;

    logic             valid;
    logic             ready;
    logic [LED_W-1:0] led_pattern;
    logic             is_running;

    modport source (output valid, led_pattern, is_running, input ready);
    modport sink   (input valid, led_pattern, is_running, output ready);
endinterface

@@ rtl/core/led_pattern_sequencer.sv @@
// LED pattern sequencer top level; depends on lps_pkg, lps_in_if and lps_out_if.
// An input transaction passes through the input register, then the result register
// holding the state update of that tick.
// Throughput: one transaction per cycle, limited only by output back-pressure.
// Reset (synchronous, active low) stops the sequence, selects fast toggle mode,
// lights all LEDs and empties both registers.
module led_pattern_sequencer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lps_in_if.sink    i_in,
    lps_out_if.source o_out
);
    import lps_pkg::*;

    logic                   r_in_valid;
    logic                   r_start_n;
    logic                   r_stop_n;
    logic [MODE_BTN_W-1:0]  r_mode_btn_n;
    logic [SPEED_BTN_W-1:0] r_speed_btn_n;

    logic             r_running,    n_running;
    logic             r_extra_wait, n_extra_wait;
    logic             r_stop_seen,  n_stop_seen;
    t_mode            r_mode,       n_mode;
    logic             r_slow,       n_slow;
    logic [LED_W-1:0] r_leds,       n_leds;
    logic [LED_W-1:0] r_left,       n_left;
    logic [LED_W-1:0] r_right,      n_right;

    logic             r_out_valid;
    logic [LED_W-1:0] r_out_leds;
    logic             r_out_running;

    logic w_advance;
    logic w_do_step;
    logic w_do_sel;
    logic w_sel_active;
    logic w_stop_now;

    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid       = r_out_valid;
    assign o_out.led_pattern = r_out_leds;
    assign o_out.is_running  = r_out_running;

    always_comb begin
        n_running    = r_running;
        n_extra_wait = r_extra_wait;
        n_stop_seen  = r_stop_seen;
        n_mode       = r_mode;
        n_slow       = r_slow;
        n_leds       = r_leds;
        n_left       = r_left;
        n_right      = r_right;
        w_do_step    = 1'b0;
        w_do_sel     = 1'b0;
        w_sel_active = 1'b0;
        w_stop_now   = r_stop_seen;

        if (!r_running) begin
            if (!r_start_n) begin
                if (r_stop_n) begin
                    n_running = 1'b1;
                    w_do_step = 1'b1;
                end
            end else begin
                w_do_sel = 1'b1;
            end
        end else if (r_extra_wait) begin
            n_extra_wait = 1'b0;
            w_do_sel     = 1'b1;
            w_sel_active = 1'b1;
        end else begin
            w_do_step = 1'b1;
        end

        if (w_do_step) begin
            w_stop_now  = !r_stop_n;
            n_stop_seen = w_stop_now;
            case (r_mode)
                MODE_TOGGLE: begin
                    n_leds = (r_leds != LEDS_ALL_ON) ? LEDS_ALL_ON : LEDS_ALL_OFF;
                end
                MODE_WALK: begin
                    n_leds = (r_leds == LEDS_HIGH_BIT) ? LEDS_LOW_BIT
                                                       : {r_leds[LED_W-2:0], 1'b0};
                end
                MODE_CONVERGE: begin
                    if (r_left == LEDS_HIGH_BIT) begin
                        n_left  = LIGHT_WRAP_LEFT;
                        n_right = LIGHT_WRAP_RIGHT;
                    end else if (r_left == LIGHT_MID_LEFT) begin
                        n_left  = LIGHT_SKIP_LEFT;
                        n_right = LIGHT_SKIP_RIGHT;
                    end else begin
                        n_left  = {r_left[LED_W-2:0], 1'b0};
                        n_right = {1'b0, r_right[LED_W-1:1]};
                    end
                    n_leds = n_left + n_right;
                end
                MODE_FILL: begin
                    n_leds = (r_leds == LEDS_ALL_ON) ? LEDS_ALL_OFF
                                                     : {r_leds[LED_W-2:0], 1'b1};
                end
                default: begin
                    n_leds = r_leds;
                end
            endcase
            if (r_slow) begin
                n_extra_wait = 1'b1;
            end else begin
                w_do_sel     = 1'b1;
                w_sel_active = 1'b1;
            end
        end

        if (w_do_sel) begin
            if (!r_mode_btn_n[0]) begin
                n_mode = MODE_TOGGLE;
            end else if (!r_mode_btn_n[1]) begin
                n_mode = MODE_WALK;
                if (w_sel_active) begin
                    n_leds = LEDS_LOW_BIT;
                end
            end else if (!r_mode_btn_n[2]) begin
                n_mode = MODE_CONVERGE;
            end else if (!r_mode_btn_n[3]) begin
                n_mode = MODE_FILL;
                if (w_sel_active) begin
                    n_leds = LEDS_ALL_OFF;
                end
            end
            if (!r_speed_btn_n[0]) begin
                n_slow = 1'b0;
            end else if (!r_speed_btn_n[1]) begin
                n_slow = 1'b1;
            end
            if (w_sel_active && w_stop_now) begin
                n_running   = 1'b0;
                n_stop_seen = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_start_n     <= i_in.start_n;
            r_stop_n      <= i_in.stop_n;
            r_mode_btn_n  <= i_in.mode_buttons_n;
            r_speed_btn_n <= i_in.speed_buttons_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_extra_wait <= 1'b0;
            r_stop_seen  <= 1'b0;
            r_mode       <= MODE_TOGGLE;
            r_slow       <= 1'b0;
            r_leds       <= LEDS_ALL_ON;
            r_left       <= LEDS_LOW_BIT;
            r_right      <= LEDS_HIGH_BIT;
        end else if (w_advance) begin
            r_running    <= n_running;
            r_extra_wait <= n_extra_wait;
            r_stop_seen  <= n_stop_seen;
            r_mode       <= n_mode;
            r_slow       <= n_slow;
            r_leds       <= n_leds;
            r_left       <= n_left;
            r_right      <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_leds    <= n_leds;
            r_out_running <= n_running;
        end
    end

    // The second tick of a slow period only exists inside a running sequence.
    a_wait_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra_wait |-> r_running)
        else $error("extra wait pending while not running");

    // A latched stop is only carried across the wait tick of a slow period.
    a_stop_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_seen |-> r_extra_wait)
        else $error("stop latched outside a slow period");

    // The state only moves when a transaction is handed to the result register.
    a_run_moves_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_running) && $stable(r_leds))
        else $error("sequencer state changed without a transaction");

    a_result_after_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid && (r_out_running == r_running))
        else $error("result register does not match the state update");

endmodule
